/* rtl/core/hilbert4d_coords_to_index_defines.svh */
// Assertion macros used by the checker file of the 4-D Hilbert index block.
`ifndef HILBERT4D_COORDS_TO_INDEX_DEFINES_SVH
`define HILBERT4D_COORDS_TO_INDEX_DEFINES_SVH

// Same-cycle implication, switched off while reset is high.
`define H4C_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("h4c assertion failed");

// Next-cycle implication, switched off while reset is high.
`define H4C_ASSERT_NEXT(label, clk, ante, cons, rst) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("h4c assertion failed");

// Next-cycle implication that also holds across reset.
`define H4C_ASSERT_ALWAYS_NEXT(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("h4c assertion failed");

`endif

/* rtl/core/h4c_pkg.sv */
// Shared widths and payload types of the 4-D Hilbert index block.
package h4c_pkg;
   localparam int unsigned CoordWidth = 32;
   localparam int unsigned IndexWidth = 64;
   localparam int unsigned IndexBits  = 2 * IndexWidth;
   localparam int unsigned MaxDims    = 4;

   typedef logic [CoordWidth-1:0] coord_type;
   typedef logic [IndexWidth-1:0] index_type;
endpackage

/* rtl/core/h4c_channels.sv */
// Valid/ready channel interfaces for points in and Hilbert indexes out.
interface h4c_req_if;
   import h4c_pkg::*;
   logic      valid;
   logic      ready;
   coord_type coord_x;
   coord_type coord_y;
   coord_type coord_z;
   coord_type coord_w;

   modport source (output valid, output coord_x, output coord_y, output coord_z,
                   output coord_w, input ready);
   modport sink   (input valid, input coord_x, input coord_y, input coord_z,
                   input coord_w, output ready);
endinterface

interface h4c_rsp_if;
   import h4c_pkg::*;
   logic      valid;
   logic      ready;
   index_type index_low;
   index_type index_high;

   modport source (output valid, output index_low, output index_high, input ready);
   modport sink   (input valid, input index_low, input index_high, output ready);
endinterface

/* rtl/core/h4c_cell.sv */
// One bit level of the axes-to-transpose rotation, registered.
module h4c_cell #(
   parameter int DIMENSIONS    = 4,
   parameter int BITS_PER_AXIS = 32,
   parameter int LEVEL         = 31
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     in_valid,
   output logic                                     in_ready,
   input  logic [DIMENSIONS-1:0][BITS_PER_AXIS-1:0] in_point,
   output logic                                     out_valid,
   input  logic                                     out_ready,
   output logic [DIMENSIONS-1:0][BITS_PER_AXIS-1:0] out_point
);
   localparam logic [BITS_PER_AXIS-1:0] LowMask =
      BITS_PER_AXIS'((64'd1 << LEVEL) - 64'd1);

   logic                                     valid_ff;
   logic                                     valid_in;
   logic [DIMENSIONS-1:0][BITS_PER_AXIS-1:0] point_ff;
   logic [DIMENSIONS-1:0][BITS_PER_AXIS-1:0] point_in;

   // Dimensions are visited in order; each step sees the axis-0 word left by the one before.
   always_comb begin
      logic [BITS_PER_AXIS-1:0] swap;
      swap     = '0;
      point_in = in_point;
      for (int d = 0; d < DIMENSIONS; d++) begin
         if (point_in[d][LEVEL]) begin
            point_in[0] = point_in[0] ^ LowMask;
         end else begin
            swap        = (point_in[0] ^ point_in[d]) & LowMask;
            point_in[0] = point_in[0] ^ swap;
            point_in[d] = point_in[d] ^ swap;
         end
      end
   end

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         point_ff <= point_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_point = point_ff;
endmodule

/* rtl/core/h4c_encode.sv */
// Gray encoding, reflection and bit interleave, with the result register.
module h4c_encode #(
   parameter int DIMENSIONS    = 4,
   parameter int BITS_PER_AXIS = 32
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     in_valid,
   output logic                                     in_ready,
   input  logic [DIMENSIONS-1:0][BITS_PER_AXIS-1:0] in_point,
   h4c_rsp_if.source                                rsp_chan
);
   import h4c_pkg::*;

   logic [DIMENSIONS-1:0][BITS_PER_AXIS-1:0] gray;
   logic [BITS_PER_AXIS-1:0]                 flip;
   logic [IndexBits-1:0]                     index_in;
   logic [IndexBits-1:0]                     index_ff;
   logic                                     valid_ff;

   always_comb begin
      gray[0] = in_point[0];
      for (int d = 1; d < DIMENSIONS; d++) begin
         gray[d] = gray[d-1] ^ in_point[d];
      end
   end

   // Each set bit of the last dimension flips every bit below it, so a flip bit is the
   // parity of the last dimension above that position.
   always_comb begin
      for (int j = 0; j < BITS_PER_AXIS; j++) begin
         flip[j] = ^(gray[DIMENSIONS-1] >> (j + 1));
      end
   end

   always_comb begin
      index_in = '0;
      for (int b = 0; b < BITS_PER_AXIS; b++) begin
         for (int d = 0; d < DIMENSIONS; d++) begin
            index_in[b*DIMENSIONS+d] = gray[d][b] ^ flip[b];
         end
      end
   end

   assign in_ready = !valid_ff || rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         index_ff <= index_in;
      end
   end

   assign rsp_chan.valid      = valid_ff;
   assign rsp_chan.index_low  = index_ff[IndexWidth-1:0];
   assign rsp_chan.index_high = index_ff[IndexBits-1:IndexWidth];
endmodule

/* rtl/core/hilbert4d_coords_to_index.sv */
// Top level: 4-D point to 128-bit Hilbert index, one bit level per pipeline cell.
//
// Usage: a point enters on req_chan (coord_x..coord_w, centered coordinates) when
// valid and ready are both high; its index leaves on rsp_chan as index_low (bits 63..0)
// and index_high (bits 127..64). Only the low BITS_PER_AXIS bits of the first
// DIMENSIONS coordinates are used; index bits above DIMENSIONS*BITS_PER_AXIS are zero.
// Pipeline: one register per rotation cell for levels BITS_PER_AXIS-1 down to 1,
// then the output register after the Gray/interleave logic.
// Throughput: one point per cycle while rsp_chan.ready is high, set by the row of
// cells that each hold one item.
// Reset clears every valid bit; no item is in flight afterwards (data is not reset).
// When the receiver stalls, the result stays on rsp_chan unchanged; empty cells keep
// taking items until the row is full, and then req_chan.ready drops.
module hilbert4d_coords_to_index #(
   parameter int DIMENSIONS    = 4,
   parameter int BITS_PER_AXIS = 32
) (
   input logic       clock,
   input logic       reset,
   h4c_req_if.sink   req_chan,
   h4c_rsp_if.source rsp_chan
);
   import h4c_pkg::*;

   localparam logic [BITS_PER_AXIS-1:0] CenterBit =
      BITS_PER_AXIS'(64'd1 << (BITS_PER_AXIS - 1));

   coord_type                                coords      [MaxDims];
   logic                                     stage_valid [BITS_PER_AXIS];
   logic                                     stage_ready [BITS_PER_AXIS];
   logic [DIMENSIONS-1:0][BITS_PER_AXIS-1:0] stage_point [BITS_PER_AXIS];

   assign coords[0] = req_chan.coord_x;
   assign coords[1] = req_chan.coord_y;
   assign coords[2] = req_chan.coord_z;
   assign coords[3] = req_chan.coord_w;

   // Flipping the top bit moves the lowest corner of the space to zero and the center to the midpoint.
   for (genvar d = 0; d < DIMENSIONS; d++) begin : g_center
      assign stage_point[0][d] = coords[d][BITS_PER_AXIS-1:0] ^ CenterBit;
   end

   assign stage_valid[0] = req_chan.valid;
   assign req_chan.ready = stage_ready[0];

   for (genvar k = 0; k < BITS_PER_AXIS - 1; k++) begin : g_cell
      h4c_cell #(
         .DIMENSIONS    (DIMENSIONS),
         .BITS_PER_AXIS (BITS_PER_AXIS),
         .LEVEL         (BITS_PER_AXIS - 1 - k)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stage_valid[k]),
         .in_ready  (stage_ready[k]),
         .in_point  (stage_point[k]),
         .out_valid (stage_valid[k+1]),
         .out_ready (stage_ready[k+1]),
         .out_point (stage_point[k+1])
      );
   end

   h4c_encode #(
      .DIMENSIONS    (DIMENSIONS),
      .BITS_PER_AXIS (BITS_PER_AXIS)
   ) u_encode (
      .clock    (clock),
      .reset    (reset),
      .in_valid (stage_valid[BITS_PER_AXIS-1]),
      .in_ready (stage_ready[BITS_PER_AXIS-1]),
      .in_point (stage_point[BITS_PER_AXIS-1]),
      .rsp_chan (rsp_chan)
   );
endmodule

/* rtl/core/h4c_checker.sv */
// Port-level checks for the 4-D Hilbert index block, bound to its top level.
`include "hilbert4d_coords_to_index_defines.svh"

module h4c_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input h4c_pkg::index_type  index_low,
   input h4c_pkg::index_type  index_high
);
   import h4c_pkg::*;

   // A reset empties the whole row, so no result may show right after it.
   `H4C_ASSERT_ALWAYS_NEXT(a_reset_clears, clock, reset, !rsp_valid)

   // With the output register empty every cell can move, so the input must be open.
   `H4C_ASSERT_NOW(a_empty_takes, clock, reset, !rsp_valid, req_ready)

   `H4C_ASSERT_NEXT(a_rsp_holds, clock, rsp_valid && !rsp_ready, rsp_valid, reset)

   `H4C_ASSERT_NEXT(a_rsp_stable, clock, rsp_valid && !rsp_ready,
                    $stable(index_low) && $stable(index_high), reset)
endmodule

bind hilbert4d_coords_to_index h4c_checker u_h4c_checker (
   .clock      (clock),
   .reset      (reset),
   .req_ready  (req_chan.ready),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .index_low  (rsp_chan.index_low),
   .index_high (rsp_chan.index_high)
);
